// ===== hdl/udpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package udpc_pkg;

	localparam logic [15:0] UDP_PROTO     = 16'd17;
	localparam logic [15:0] CSUM_FIELD_HI = 16'd6;
	localparam logic [15:0] CSUM_FIELD_LO = 16'd7;
	localparam logic [15:0] ALL_ONES      = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first;
		logic        last;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} udpc_in_t;

	typedef struct packed {
		logic [15:0] checksum_value;
		logic [15:0] segment_length;
		logic        length_overflow;
	} udpc_out_t;

	typedef struct packed {
		logic        first;
		logic        last;
		logic        word_valid;
		logic [15:0] word;
		logic [17:0] addr_sum;
		logic [15:0] seg_len;
		logic        len_ovf;
	} udpc_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} udpc_q_status_t;

	// two end-around carry folds bring any 19-bit sum back to 16 bits
	function automatic logic [15:0] oc_fold(input logic [18:0] t);
		logic [16:0] a;
		logic [16:0] b;
		a = {1'b0, t[15:0]} + {14'b0, t[18:16]};
		b = {1'b0, a[15:0]} + {16'b0, a[16]};
		return b[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/udp_checksum_stream.sv =====
// the result transaction is valid once the last byte has passed the queue, the fin_s1 stage and the output register
// throughput: one byte per cycle while the queue is not full; the back end's 16-bit accumulate loop sets the pace
// a small queue between front and back absorbs output stalls
// reset: arst_n clears the byte counter, accumulator, queue and valid flags at once
`timescale 1ns / 1ps
`default_nettype none

module udp_checksum_stream
	import udpc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire udpc_in_t  in_item,
	output      logic      out_valid,
	input  wire logic      out_ready,
	output      udpc_out_t out_item
);

	udpc_q_status_t q_status;
	udpc_entry_t    wr_entry;
	udpc_entry_t    rd_entry;
	logic           push;
	logic           pop;

	udpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_status (q_status),
		.push     (push),
		.entry    (wr_entry)
	);

	udpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (q_status)
	);

	udpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.entry     (rd_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_csum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.checksum_value != 16'd0))
		else $error("checksum zero on output");

	a_ovf_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.length_overflow) |-> (out_item.segment_length == ALL_ONES))
		else $error("overflowed length not saturated");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue full and empty together");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> !pop)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/udpc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udpc_front
	import udpc_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire udpc_in_t       in_item,
	input  wire udpc_q_status_t q_status,
	output      logic           push,
	output      udpc_entry_t    entry
);

	logic [15:0] byte_count_q;
	logic        overflow_q;
	logic [7:0]  held_q;

	logic [15:0] idx;
	logic        ovf;
	logic [7:0]  held;
	logic [7:0]  b;
	logic [15:0] count_next;
	logic        ovf_next;

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		idx        = in_item.first ? 16'd0 : byte_count_q;
		ovf        = in_item.first ? 1'b0 : overflow_q;
		held       = in_item.first ? 8'd0 : held_q;
		b          = in_item.data_byte;
		// checksum field counts as zero
		if (!ovf && (idx == CSUM_FIELD_HI || idx == CSUM_FIELD_LO)) begin
			b = 8'd0;
		end
		count_next = idx + 16'd1;
		ovf_next   = ovf || (count_next == 16'd0);

		entry.first      = in_item.first;
		entry.last       = in_item.last;
		entry.word_valid = idx[0] || in_item.last;
		entry.word       = idx[0] ? {held, b} : {b, 8'd0};
		entry.addr_sum   = {2'b0, in_item.src_addr[31:16]} + {2'b0, in_item.src_addr[15:0]}
			+ {2'b0, in_item.dst_addr[31:16]} + {2'b0, in_item.dst_addr[15:0]};
		entry.seg_len    = ovf_next ? ALL_ONES : count_next;
		entry.len_ovf    = ovf_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			overflow_q   <= 1'b0;
			held_q       <= '0;
		end else if (push) begin
			if (in_item.last) begin
				byte_count_q <= '0;
				overflow_q   <= 1'b0;
				held_q       <= '0;
			end else begin
				byte_count_q <= count_next;
				overflow_q   <= ovf_next;
				held_q       <= idx[0] ? 8'd0 : b;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/udpc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udpc_queue
	import udpc_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire udpc_entry_t    wr_entry,
	input  wire logic           pop,
	output      udpc_entry_t    rd_entry,
	output      udpc_q_status_t status
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	udpc_entry_t   slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rd_entry     = slots_q[rd_ptr_q];
	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/udpc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module udpc_back
	import udpc_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire udpc_q_status_t q_status,
	input  wire udpc_entry_t    entry,
	output      logic           pop,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      udpc_out_t      out_item
);

	logic [15:0] acc_q;
	logic        fin_valid_s1;
	logic [15:0] fin_sum_s1;
	logic [15:0] fin_len_s1;
	logic        fin_ovf_s1;
	logic        out_valid_q;
	udpc_out_t   out_q;

	logic        out_load_ok;
	logic        fin_ready;
	logic [17:0] base;
	logic [18:0] acc_sum;
	logic [15:0] acc_next;
	logic [18:0] fin_total;
	logic [15:0] fin_fold;
	logic [15:0] csum;

	assign out_load_ok = !out_valid_q || out_ready;
	assign fin_ready   = !fin_valid_s1 || out_load_ok;
	assign pop         = !q_status.empty && (!entry.last || fin_ready);

	always_comb begin
		base      = entry.first ? entry.addr_sum : {2'b0, acc_q};
		acc_sum   = {1'b0, base} + {3'b0, (entry.word_valid ? entry.word : 16'd0)};
		acc_next  = oc_fold(acc_sum);
		fin_total = {3'b0, fin_sum_s1} + {3'b0, UDP_PROTO} + {3'b0, fin_len_s1};
		fin_fold  = oc_fold(fin_total);
		csum      = ~fin_fold;
		if (csum == 16'd0) begin
			csum = ALL_ONES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			fin_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= entry.last ? 16'd0 : acc_next;
			end
			if (fin_ready) begin
				fin_valid_s1 <= pop && entry.last;
			end
			if (out_load_ok) begin
				out_valid_q <= fin_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && entry.last) begin
			fin_sum_s1 <= acc_next;
			fin_len_s1 <= entry.seg_len;
			fin_ovf_s1 <= entry.len_ovf;
		end
		if (fin_valid_s1 && out_load_ok) begin
			out_q.checksum_value  <= csum;
			out_q.segment_length  <= fin_len_s1;
			out_q.length_overflow <= fin_ovf_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire
